// File: rtl/core/assert_macros.svh
// Assertion shorthands for the tokenizer checkers.
// Each macro samples on the rising edge of clk and is off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge.
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_IMPLIES_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/cft_pkg.sv
`timescale 1ns / 1ps

package cft_pkg;

  // Default sizing of the column and row counters.
  localparam int DEF_MAX_COLUMNS    = 256;
  localparam int DEF_ROW_INDEX_BITS = 24;

  // Reset values of the configuration registers.
  localparam logic [7:0] DELIM_RESET = 8'd44;
  localparam logic [7:0] QUOTE_RESET = 8'd34;

  // Fixed control bytes.
  localparam logic [7:0] LINE_FEED       = 8'h0A;
  localparam logic [7:0] CARRIAGE_RETURN = 8'h0D;

  // Configuration register indexes.
  localparam logic CFG_DELIMITER = 1'b0;
  localparam logic CFG_QUOTE     = 1'b1;

  // Result item kinds.
  localparam logic [1:0] KIND_DATA      = 2'd0;
  localparam logic [1:0] KIND_FIELD_END = 2'd1;
  localparam logic [1:0] KIND_ROW_END   = 2'd2;

  // Output queue sizing.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Per-field parser flags.
  typedef struct packed {
    logic       inside_quotes;
    logic       quote_maybe_closing;
    logic       unescape_pending_quote;
    logic       held_first_quote;
    logic [1:0] field_output_count;
    logic       field_had_quote;
    logic       field_truncated;
    logic       row_has_bytes;
  } flags_t;

  // One result item.
  typedef struct packed {
    logic [1:0]  item_kind;
    logic [7:0]  field_byte;
    logic [23:0] row_number;
    logic [7:0]  column_number;
    logic        field_is_null;
    logic        last_of_run;
  } res_t;

endpackage

// File: rtl/core/cft_step.sv
`timescale 1ns / 1ps

module cft_step #(
  parameter int MAX_COLUMNS    = cft_pkg::DEF_MAX_COLUMNS,
  parameter int ROW_INDEX_BITS = cft_pkg::DEF_ROW_INDEX_BITS,
  parameter int COL_W          = $clog2(MAX_COLUMNS + 1)
) (
  input  cft_pkg::flags_t             flags_i,
  input  logic [COL_W-1:0]            col_i,
  input  logic [ROW_INDEX_BITS-1:0]   row_i,
  input  logic [COL_W-1:0]            hdr_i,
  input  logic [7:0]                  text_byte,
  input  logic                        end_of_text,
  input  logic [7:0]                  delimiter_byte,
  input  logic [7:0]                  quote_byte,
  output cft_pkg::flags_t             flags_o,
  output logic [COL_W-1:0]            col_o,
  output logic [ROW_INDEX_BITS-1:0]   row_o,
  output logic [COL_W-1:0]            hdr_o,
  output cft_pkg::res_t               res0_o,
  output cft_pkg::res_t               res1_o,
  output logic [1:0]                  res_cnt_o
);
  import cft_pkg::*;

  localparam logic [COL_W-1:0] COL_MAX = COL_W'(MAX_COLUMNS);

  flags_t                    fl;
  logic [COL_W-1:0]          c;
  logic [ROW_INDEX_BITS-1:0] r;
  logic [COL_W-1:0]          h;
  logic [1:0]                n;
  res_t                      res_v [2];
  logic                      kept;
  logic                      is_q;
  logic                      handled;
  logic                      do_content;
  logic                      do_close_field;
  logic                      do_close_row;
  logic                      do_emit;

  // Builds a result item with the row index of the current row.
  function automatic res_t mk_res(input logic [1:0] kind, input logic [7:0] byte_v,
                                  input logic [COL_W-1:0] col,
                                  input logic [ROW_INDEX_BITS-1:0] row,
                                  input logic null_flag);
    res_t x;
    x.item_kind     = kind;
    x.field_byte    = byte_v;
    x.row_number    = 24'(row);
    x.column_number = 8'(col);
    x.field_is_null = null_flag;
    x.last_of_run   = 1'b0;
    return x;
  endfunction

  // One input item: classify the byte, update the field flags and collect results.
  always_comb begin
    fl             = flags_i;
    c              = col_i;
    r              = row_i;
    h              = hdr_i;
    n              = 2'd0;
    res_v[0]       = '0;
    res_v[1]       = '0;
    handled        = 1'b0;
    do_content     = 1'b0;
    do_close_field = 1'b0;
    do_close_row   = 1'b0;
    do_emit        = 1'b0;
    is_q           = (text_byte == quote_byte);
    kept           = (row_i == '0) ? (col_i < COL_MAX) : (col_i < hdr_i);

    if (end_of_text) begin
      // Close the open row only if it holds anything, then return to the reset state.
      if (flags_i.row_has_bytes) begin
        if (kept) begin
          res_v[n[0]] = mk_res(KIND_FIELD_END, 8'd0, col_i, row_i,
                               !flags_i.field_had_quote &&
                               (flags_i.field_output_count == 2'd0));
          n = n + 2'd1;
        end
        res_v[n[0]] = mk_res(KIND_ROW_END, 8'd0, col_i, row_i, 1'b0);
        n = n + 2'd1;
      end
      fl = '0;
      c  = '0;
      r  = '0;
      h  = '0;
    end else begin
      // A quote seen inside quotes is settled by the byte after it.
      if (fl.quote_maybe_closing) begin
        fl.quote_maybe_closing = 1'b0;
        if (is_q) begin
          fl.row_has_bytes   = 1'b1;
          fl.field_had_quote = 1'b1;
          do_content         = 1'b1;
          handled            = 1'b1;
        end else begin
          fl.inside_quotes = 1'b0;
        end
      end

      // Byte classification; quote wins over delimiter, then line feed, then CR.
      if (!handled) begin
        if (is_q) begin
          fl.row_has_bytes   = 1'b1;
          fl.field_had_quote = 1'b1;
          if (fl.inside_quotes) begin
            fl.quote_maybe_closing = 1'b1;
          end else begin
            fl.inside_quotes = 1'b1;
          end
          do_content = 1'b1;
        end else if (!fl.inside_quotes && (text_byte == delimiter_byte)) begin
          fl.row_has_bytes = 1'b1;
          do_close_field   = 1'b1;
        end else if (!fl.inside_quotes && (text_byte == LINE_FEED)) begin
          do_close_row = 1'b1;
        end else if (!fl.inside_quotes && (text_byte == CARRIAGE_RETURN)) begin
          fl.field_truncated = 1'b1;
        end else begin
          fl.row_has_bytes = 1'b1;
          do_content       = 1'b1;
        end
      end

      // Unescaping of field content.
      if (do_content && kept && !fl.field_truncated) begin
        if ((text_byte == 8'd0) && !is_q) begin
          fl.field_truncated = 1'b1;
        end else if (fl.unescape_pending_quote) begin
          fl.unescape_pending_quote = 1'b0;
          do_emit                   = 1'b1;
        end else if (is_q) begin
          fl.unescape_pending_quote = 1'b1;
        end else begin
          do_emit = 1'b1;
        end
      end

      // A leading quote is held back until a second output byte shows up.
      if (do_emit) begin
        if ((fl.field_output_count == 2'd0) && is_q) begin
          fl.held_first_quote   = 1'b1;
          fl.field_output_count = 2'd1;
        end else begin
          if (fl.held_first_quote) begin
            res_v[n[0]] = mk_res(KIND_DATA, quote_byte, col_i, row_i, 1'b0);
            n = n + 2'd1;
            fl.held_first_quote = 1'b0;
          end
          res_v[n[0]] = mk_res(KIND_DATA, text_byte, col_i, row_i, 1'b0);
          n = n + 2'd1;
          if (fl.field_output_count != 2'd2) begin
            fl.field_output_count = fl.field_output_count + 2'd1;
          end
        end
      end

      // Field close, shared by the delimiter and the line end.
      if (do_close_field || do_close_row) begin
        if (kept) begin
          res_v[n[0]] = mk_res(KIND_FIELD_END, 8'd0, col_i, row_i,
                               !fl.field_had_quote && (fl.field_output_count == 2'd0));
          n = n + 2'd1;
          if (row_i == '0) begin
            h = col_i + COL_W'(1);
          end
        end
        fl.unescape_pending_quote = 1'b0;
        fl.held_first_quote       = 1'b0;
        fl.field_output_count     = 2'd0;
        fl.field_had_quote        = 1'b0;
        fl.field_truncated        = 1'b0;
        if (col_i < COL_MAX) begin
          c = col_i + COL_W'(1);
        end
      end

      // Row close: end-of-row marker, next row index, first column.
      if (do_close_row) begin
        res_v[n[0]] = mk_res(KIND_ROW_END, 8'd0, col_i, row_i, 1'b0);
        n = n + 2'd1;
        if (row_i != {ROW_INDEX_BITS{1'b1}}) begin
          r = row_i + ROW_INDEX_BITS'(1);
        end
        c                = '0;
        fl.row_has_bytes = 1'b0;
      end
    end

    // Mark the final result of this item.
    if (n == 2'd1) begin
      res_v[0].last_of_run = 1'b1;
    end else if (n == 2'd2) begin
      res_v[1].last_of_run = 1'b1;
    end
  end

  assign flags_o   = fl;
  assign col_o     = c;
  assign row_o     = r;
  assign hdr_o     = h;
  assign res0_o    = res_v[0];
  assign res1_o    = res_v[1];
  assign res_cnt_o = n;

endmodule

// File: rtl/core/cft_out_queue.sv
`timescale 1ns / 1ps

module cft_out_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [1:0]    push_cnt,
  input  cft_pkg::res_t push0,
  input  cft_pkg::res_t push1,
  output logic          has_room,
  output logic          head_valid,
  input  logic          head_ready,
  output cft_pkg::res_t head
);
  import cft_pkg::*;

  res_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wp_r;
  logic [QPTR_W-1:0] wp_nxt;
  logic [QPTR_W-1:0] rp_r;
  logic [QPTR_W-1:0] rp_nxt;
  logic [QCNT_W-1:0] count_r;
  logic [QCNT_W-1:0] count_nxt;
  logic              pop;

  // Pointer and fill bookkeeping; up to two items in and one out per cycle.
  assign pop        = head_valid && head_ready;
  assign wp_nxt     = wp_r + QPTR_W'(push_cnt);
  assign rp_nxt     = rp_r + QPTR_W'(pop);
  assign count_nxt  = count_r + QCNT_W'(push_cnt) - QCNT_W'(pop);
  assign has_room   = (count_r <= QCNT_W'(QUEUE_DEPTH - 2));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      count_r <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem_r[wp_r] <= push0;
    end
    if (push_cnt == 2'd2) begin
      mem_r[wp_r + QPTR_W'(1)] <= push1;
    end
  end

endmodule

// File: rtl/core/csv_field_tokenizer.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake                 Carries
// in_      input      in_tvalid / in_tready     text byte (tdata), end of text (tlast)
// out_     output     out_tvalid / out_tready   byte, row, column (tdata); kind, null (tuser)
// cfg_     input      cfg_we                    delimiter (index 0), quote (index 1)
//
// An accepted item waits in the input register until the queue can take two results;
// its results then enter a four-entry output queue, whose head drives the output port.
// One item per cycle enters while out_tready is high and each makes at most one result;
// the output port moves one result per cycle, so two-result items back up the input.
// Reset is synchronous and clears the parser state and queue; the delimiter returns to
// a comma and the quote to a double quote. The input register holds while the queue has
// fewer than two free entries.

module csv_field_tokenizer #(
  parameter int MAX_COLUMNS    = cft_pkg::DEF_MAX_COLUMNS,
  parameter int ROW_INDEX_BITS = cft_pkg::DEF_ROW_INDEX_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  input  logic        in_tlast,   // end_of_text
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [7:0] field_byte, [31:8] row_number, [39:32] column_number
  output logic [2:0]  out_tuser,  // [1:0] item_kind, [2] field_is_null
  output logic        out_tlast,  // last_of_run
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [7:0]  cfg_wdata
);
  import cft_pkg::*;

  localparam int COL_W = $clog2(MAX_COLUMNS + 1);

  logic [7:0]                delim_r;
  logic [7:0]                quote_r;
  logic                      in_valid_r;
  logic [7:0]                in_byte_r;
  logic                      in_eot_r;
  flags_t                    flags_r;
  flags_t                    flags_nxt;
  logic [COL_W-1:0]          col_r;
  logic [COL_W-1:0]          col_nxt;
  logic [ROW_INDEX_BITS-1:0] row_r;
  logic [ROW_INDEX_BITS-1:0] row_nxt;
  logic [COL_W-1:0]          hdr_r;
  logic [COL_W-1:0]          hdr_nxt;
  res_t                      res0;
  res_t                      res1;
  logic [1:0]                res_cnt;
  logic                      has_room;
  logic                      fire;
  res_t                      head;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r <= DELIM_RESET;
      quote_r <= QUOTE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_DELIMITER: delim_r <= cfg_wdata;
        CFG_QUOTE:     quote_r <= cfg_wdata;
        default:       delim_r <= delim_r;
      endcase
    end
  end

  // Input register; the item is processed once the queue can take two results.
  assign fire      = in_valid_r && has_room;
  assign in_tready = !in_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_eot_r  <= in_tlast;
    end
  end

  // Parser decisions for the registered item.
  cft_step #(
    .MAX_COLUMNS    (MAX_COLUMNS),
    .ROW_INDEX_BITS (ROW_INDEX_BITS),
    .COL_W          (COL_W)
  ) u_step (
    .flags_i        (flags_r),
    .col_i          (col_r),
    .row_i          (row_r),
    .hdr_i          (hdr_r),
    .text_byte      (in_byte_r),
    .end_of_text    (in_eot_r),
    .delimiter_byte (delim_r),
    .quote_byte     (quote_r),
    .flags_o        (flags_nxt),
    .col_o          (col_nxt),
    .row_o          (row_nxt),
    .hdr_o          (hdr_nxt),
    .res0_o         (res0),
    .res1_o         (res1),
    .res_cnt_o      (res_cnt)
  );

  // Parser state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
      col_r   <= '0;
      row_r   <= '0;
      hdr_r   <= '0;
    end else if (fire) begin
      flags_r <= flags_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      hdr_r   <= hdr_nxt;
    end
  end

  // Result queue between the parser and the output port.
  cft_out_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_cnt   (fire ? res_cnt : 2'd0),
    .push0      (res0),
    .push1      (res1),
    .has_room   (has_room),
    .head_valid (out_tvalid),
    .head_ready (out_tready),
    .head       (head)
  );

  assign out_tdata = {head.column_number, head.row_number, head.field_byte};
  assign out_tuser = {head.field_is_null, head.item_kind};
  assign out_tlast = head.last_of_run;

endmodule

// File: rtl/core/cft_checker.sv
`timescale 1ns / 1ps

`include "assert_macros.svh"

module cft_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);
  import cft_pkg::*;

  // A stalled result item keeps its contents.
  `ASSERT_IMPLIES_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "output item changed while stalled")

  // The null flag only appears on end-of-field markers.
  `ASSERT_IMPLIES(a_null_on_field_end, out_tvalid && out_tuser[2], out_tuser[1:0] == KIND_FIELD_END, "null flag on a non field-end item")

  // End of row is always the final result of its input item.
  `ASSERT_IMPLIES(a_row_end_last, out_tvalid && (out_tuser[1:0] == KIND_ROW_END), out_tlast, "row end without last flag")

  // Markers carry a zero byte.
  `ASSERT_IMPLIES(a_marker_byte_zero, out_tvalid && (out_tuser[1:0] != KIND_DATA), out_tdata[7:0] == 8'd0, "marker with nonzero byte")

endmodule

bind csv_field_tokenizer cft_checker u_cft_checker (.*);

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import cft_pkg::*;

  localparam int MAX_COLS = DEF_MAX_COLUMNS;
  localparam int ROW_BITS = DEF_ROW_INDEX_BITS;
  localparam int PHASES   = 8;
  localparam int PHASE_ITEMS = 180;

  typedef struct {
    logic [7:0] text_byte;
    logic       end_of_text;
  } text_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;  // [7:0] text_byte
  logic        in_tlast = 1'b0;   // end_of_text
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;         // [7:0] field_byte, [31:8] row_number, [39:32] column_number
  logic [2:0]  out_tuser;         // [1:0] item_kind, [2] field_is_null
  logic        out_tlast;         // last_of_run
  logic        cfg_we = 1'b0;
  logic        cfg_addr = 1'b0;
  logic [7:0]  cfg_wdata = 8'h00;

  csv_field_tokenizer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // Free-running clock, 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Stimulus and expectation stores.
  text_item_t pending_text[$];
  res_t       expected_tokens[$];
  res_t       step_tokens[$];
  int         queued_count = 0;
  int         accepted_count = 0;
  int         fail_count = 0;
  int         text_gap = 0;
  int         sink_gap = 0;
  int         text_idle_mode = 0;
  int         sink_idle_mode = 0;
  text_item_t staged;
  int         stall;

  // Tokenizer state as the predictor sees it.
  logic [7:0]          delim_b;
  logic [7:0]          quote_b;
  logic                in_quotes;
  logic                quote_pending_close;
  logic                skip_quote;
  logic                first_quote_held;
  logic [1:0]          field_bytes;
  logic                field_quoted;
  logic                field_cut;
  logic [8:0]          col_idx;
  logic [ROW_BITS-1:0] row_idx;
  logic [8:0]          header_cols;
  logic                row_started;

  function automatic void clear_parser();
    in_quotes = 1'b0;
    quote_pending_close = 1'b0;
    skip_quote = 1'b0;
    first_quote_held = 1'b0;
    field_bytes = 2'd0;
    field_quoted = 1'b0;
    field_cut = 1'b0;
    col_idx = '0;
    row_idx = '0;
    header_cols = '0;
    row_started = 1'b0;
  endfunction

  // At most two results per input item; further ones are never produced.
  function automatic void emit(logic [1:0] kind, logic [7:0] b, logic [8:0] col, logic nul);
    res_t r;
    if (step_tokens.size() >= 2) return;
    r.item_kind     = kind;
    r.field_byte    = b;
    r.row_number    = row_idx[23:0];
    r.column_number = col[7:0];
    r.field_is_null = nul;
    r.last_of_run   = 1'b0;
    step_tokens.push_back(r);
  endfunction

  // Row 0 keeps up to MAX_COLS columns; later rows keep the header's count.
  function automatic logic column_kept();
    if (row_idx == 0) return col_idx < MAX_COLS;
    return col_idx < header_cols;
  endfunction

  // A leading quote in the output is held back until a second byte follows it.
  function automatic void emit_data(logic [7:0] x);
    if (field_bytes == 2'd0 && x == quote_b) begin
      first_quote_held = 1'b1;
      field_bytes = 2'd1;
      return;
    end
    if (first_quote_held) begin
      emit(KIND_DATA, quote_b, col_idx, 1'b0);
      first_quote_held = 1'b0;
    end
    emit(KIND_DATA, x, col_idx, 1'b0);
    if (field_bytes < 2'd2) field_bytes = field_bytes + 2'd1;
  endfunction

  // Unescape: a quote pair gives one quote, a lone quote is dropped.
  function automatic void content_byte(logic [7:0] b);
    if (!column_kept() || field_cut) return;
    if (b == 8'h00 && b != quote_b) begin
      field_cut = 1'b1;
      return;
    end
    if (skip_quote) begin
      skip_quote = 1'b0;
      emit_data(b);
    end else if (b == quote_b) begin
      skip_quote = 1'b1;
    end else begin
      emit_data(b);
    end
  endfunction

  function automatic void close_field();
    if (column_kept()) begin
      emit(KIND_FIELD_END, 8'h00, col_idx, !field_quoted && field_bytes == 2'd0);
      if (row_idx == 0) header_cols = col_idx + 9'd1;
    end
    skip_quote = 1'b0;
    first_quote_held = 1'b0;
    field_bytes = 2'd0;
    field_quoted = 1'b0;
    field_cut = 1'b0;
    if (col_idx < MAX_COLS) col_idx = col_idx + 9'd1;
  endfunction

  function automatic void close_row();
    logic [8:0] last_col;
    last_col = col_idx;
    close_field();
    emit(KIND_ROW_END, 8'h00, last_col, 1'b0);
  endfunction

  // Works out the results of one accepted text item and queues them.
  function automatic void tokenize_byte(logic [7:0] b, logic eot);
    logic handled;
    res_t r;
    step_tokens.delete();
    handled = 1'b0;
    if (eot) begin
      if (row_started) close_row();
      clear_parser();
    end else begin
      if (quote_pending_close) begin
        quote_pending_close = 1'b0;
        if (b == quote_b) begin
          row_started = 1'b1;
          field_quoted = 1'b1;
          content_byte(b);
          handled = 1'b1;
        end else begin
          in_quotes = 1'b0;
        end
      end
      if (!handled) begin
        if (b == quote_b) begin
          row_started = 1'b1;
          field_quoted = 1'b1;
          if (in_quotes) quote_pending_close = 1'b1;
          else in_quotes = 1'b1;
          content_byte(b);
        end else if (!in_quotes && b == delim_b) begin
          row_started = 1'b1;
          close_field();
        end else if (!in_quotes && b == LINE_FEED) begin
          close_row();
          if (row_idx != '1) row_idx = row_idx + ROW_BITS'(1);
          col_idx = '0;
          row_started = 1'b0;
        end else if (!in_quotes && b == CARRIAGE_RETURN) begin
          field_cut = 1'b1;
        end else begin
          row_started = 1'b1;
          content_byte(b);
        end
      end
    end
    for (int i = 0; i < step_tokens.size(); i++) begin
      r = step_tokens[i];
      r.last_of_run = (i == step_tokens.size() - 1);
      expected_tokens.push_back(r);
    end
  endfunction

  // Per-item wait: none, occasional, or uniform over the full range.
  function automatic int draw_gap(int mode);
    if (mode == 0) return 0;
    if (mode == 1) return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 17) : 0;
    return $urandom_range(0, 17);
  endfunction

  // Text driver: one item held on the bus until the tokenizer takes it.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      text_gap <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        tokenize_byte(in_tdata, in_tlast);
        accepted_count++;
      end
      if (!in_tvalid || in_tready) begin
        if (text_gap != 0) begin
          text_gap <= text_gap - 1;
          in_tvalid <= 1'b0;
        end else if (pending_text.size() != 0) begin
          staged = pending_text.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= staged.text_byte;
          in_tlast <= staged.end_of_text;
          text_gap <= draw_gap(text_idle_mode);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  task automatic check_token();
    res_t want;
    if (expected_tokens.size() == 0) begin
      fail_count++;
      $display("%0t: unexpected item, expected none, actual tdata %0h tuser %0h tlast %0b",
               $time, out_tdata, out_tuser, out_tlast);
    end else begin
      want = expected_tokens.pop_front();
      check_field("item_kind", want.item_kind, out_tuser[1:0]);
      check_field("field_byte", want.field_byte, out_tdata[7:0]);
      check_field("row_number", want.row_number, out_tdata[31:8]);
      check_field("column_number", want.column_number, out_tdata[39:32]);
      check_field("field_is_null", want.field_is_null, out_tuser[2]);
      check_field("last_of_run", want.last_of_run, out_tlast);
    end
  endtask

  // Result monitor with random back-pressure after each item.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      sink_gap <= 0;
    end else if (out_tvalid && out_tready) begin
      check_token();
      stall = draw_gap(sink_idle_mode);
      sink_gap <= stall;
      out_tready <= (stall == 0);
    end else if (sink_gap != 0) begin
      sink_gap <= sink_gap - 1;
      out_tready <= (sink_gap == 1);
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic add_item(input logic [7:0] b, input logic eot);
    text_item_t t;
    t.text_byte = b;
    t.end_of_text = eot;
    pending_text.push_back(t);
    queued_count++;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_item(s[i], 1'b0);
  endtask

  task automatic add_eot();
    add_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Byte that is not the delimiter, the quote, a line feed or a carriage return.
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do begin
      case ($urandom_range(0, 19))
        0: b = 8'h00;
        1, 2, 3, 4: b = 8'($urandom_range(0, 255));
        default: b = 8'($urandom_range(32, 126));
      endcase
    end while (b == delim_b || b == quote_b || b == LINE_FEED || b == CARRIAGE_RETURN);
    return b;
  endfunction

  // Byte biased toward the control bytes, for broken sequences.
  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 5))
      0: return quote_b;
      1: return delim_b;
      2: return LINE_FEED;
      3: return CARRIAGE_RETURN;
      4: return 8'h00;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // One field: unquoted, quoted with escaped content, cut short, or noise.
  task automatic add_field(input logic sparse);
    logic [7:0] b;
    int n;
    if (sparse && $urandom_range(0, 15) != 0) return;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        n = $urandom_range(0, 4);
        repeat (n) add_item(plain_byte(), 1'b0);
      end
      5, 6, 7: begin
        add_item(quote_b, 1'b0);
        n = $urandom_range(0, 4);
        repeat (n) begin
          case ($urandom_range(0, 9))
            0: b = delim_b;
            1: b = LINE_FEED;
            2: b = CARRIAGE_RETURN;
            3: b = quote_b;
            4, 5: b = 8'($urandom_range(0, 255));
            default: b = 8'($urandom_range(32, 126));
          endcase
          add_item(b, 1'b0);
          if (b == quote_b) add_item(b, 1'b0);
        end
        add_item(quote_b, 1'b0);
        if ($urandom_range(0, 7) == 0) add_item(plain_byte(), 1'b0);
      end
      8: begin
        n = $urandom_range(1, 4);
        repeat (n) add_item(noise_byte(), 1'b0);
      end
      default: begin
        if ($urandom_range(0, 1) == 0) begin
          add_item(quote_b, 1'b0);
          add_item(quote_b, 1'b0);
        end else begin
          add_item(plain_byte(), 1'b0);
          add_item(CARRIAGE_RETURN, 1'b0);
          add_item(plain_byte(), 1'b0);
          add_item(quote_b, 1'b0);
          add_item(quote_b, 1'b0);
        end
      end
    endcase
  endtask

  // A document of rows, closed by end of text in one of several ways.
  task automatic add_document(input int hdr_cols, input int rows, input logic sparse);
    int ncols;
    for (int r = 0; r < rows; r++) begin
      if (r == 0) begin
        ncols = hdr_cols;
      end else begin
        case ($urandom_range(0, 5))
          0: ncols = $urandom_range(1, hdr_cols);
          1: ncols = hdr_cols + $urandom_range(1, 2);
          default: ncols = hdr_cols;
        endcase
      end
      for (int c = 0; c < ncols; c++) begin
        if (c > 0) add_item(delim_b, 1'b0);
        add_field(sparse);
      end
      if (r < rows - 1) begin
        if ($urandom_range(0, 4) == 0) add_item(CARRIAGE_RETURN, 1'b0);
        add_item(LINE_FEED, 1'b0);
      end
    end
    case ($urandom_range(0, 3))
      0: add_eot();
      1: begin
        add_item(LINE_FEED, 1'b0);
        add_eot();
      end
      2: begin
        add_item(LINE_FEED, 1'b0);
        add_item(CARRIAGE_RETURN, 1'b0);
        add_item(CARRIAGE_RETURN, 1'b0);
        add_eot();
      end
      default: begin
        add_item(quote_b, 1'b0);
        add_item(plain_byte(), 1'b0);
        add_eot();
      end
    endcase
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_DELIMITER) delim_b = val;
    else quote_b = val;
  endtask

  // Waits until every item is taken and every result seen, then lets the pipe empty.
  task automatic wait_drained();
    @(negedge clk);
    while (accepted_count != queued_count || expected_tokens.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Main sequence: reset, then phases under different control-byte settings.
  initial begin
    logic [7:0] delim_set [PHASES];
    logic [7:0] quote_set [PHASES];
    int phase_start;
    delim_set = '{8'd44, 8'd9, 8'd0, 8'd255, 8'd59, 8'd10, 8'd44, 8'd13};
    quote_set = '{8'd34, 8'd39, 8'd255, 8'd0, 8'd59, 8'd34, 8'd13, 8'd10};
    delim_b = DELIM_RESET;
    quote_b = QUOTE_RESET;
    clear_parser();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < PHASES; p++) begin
      write_reg(CFG_DELIMITER, delim_set[p]);
      write_reg(CFG_QUOTE, quote_set[p]);
      text_idle_mode = $urandom_range(0, 2);
      sink_idle_mode = $urandom_range(0, 2);
      phase_start = queued_count;
      if (p == 0) begin
        // Quote pairs, empty and null fields, CR and NUL cutting a field short.
        add_text("\"a\"\"b\",,x");
        add_item(CARRIAGE_RETURN, 1'b0);
        add_text("y\"\"");
        add_item(8'h00, 1'b0);
        add_item(LINE_FEED, 1'b0);
        // Field that unescapes to a lone quote, and a column past the header.
        add_text("\"\",z,,q");
        add_eot();
        // Trailing row of carriage returns only.
        add_item(CARRIAGE_RETURN, 1'b0);
        add_item(CARRIAGE_RETURN, 1'b0);
        add_eot();
        // Header wider than the column limit.
        add_document(MAX_COLS + 2, 2, 1'b1);
      end
      while (queued_count - phase_start < PHASE_ITEMS)
        add_document($urandom_range(1, 6), $urandom_range(1, 6), 1'b0);
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/cft_pkg.sv
rtl/core/cft_step.sv
rtl/core/cft_out_queue.sv
rtl/core/csv_field_tokenizer.sv
rtl/core/cft_checker.sv
tb/tb.sv
